@@ sv/gstb_pkg.sv @@
// shared types and codes of the grouped soft timer bank
package gstb_pkg;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_RUN    = 3'd1,
        KIND_CREATE = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_READY  = 3'd4,
        KIND_RESET  = 3'd5,
        KIND_PAUSE  = 3'd6,
        KIND_RESUME = 3'd7
    } t_kind;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic CFG_GROUPS_IN_USE = 1'b0;
    localparam logic CFG_TICK_RUNS     = 1'b1;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] reload;
        logic        auto_reload;
        logic        enable;
    } t_entry;

    typedef struct packed {
        logic dec;
        logic check;
        logic copy_next;
        logic write_new;
        logic set_ready;
        logic set_reset;
        logic set_pause;
        logic set_resume;
    } t_slot_ctl;

endpackage

@@ sv/gstb_cell.sv @@
// one timer entry of the circulating chain
module gstb_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  gstb_pkg::t_entry i_d,
    output gstb_pkg::t_entry o_q
);

    gstb_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_d;
        end
    end

    assign o_q = r_entry;

endmodule

@@ sv/gstb_proc.sv @@
// update unit applied to the entry at the head of the chain
module gstb_proc (
    input  gstb_pkg::t_slot_ctl i_ctl,
    input  gstb_pkg::t_entry    i_head,
    input  gstb_pkg::t_entry    i_next,
    input  gstb_pkg::t_entry    i_new,
    output gstb_pkg::t_entry    o_entry,
    output logic                o_fire
);

    gstb_pkg::t_entry w_dec;

    always_comb begin
        w_dec = i_head;
        if (i_ctl.dec && i_head.enable && (i_head.count != 32'd0)) begin
            w_dec.count = i_head.count - 32'd1;
        end
    end

    always_comb begin
        o_entry = w_dec;
        o_fire  = 1'b0;
        priority if (i_ctl.check) begin
            if (w_dec.count == 32'd0) begin
                o_fire         = 1'b1;
                o_entry.count  = w_dec.reload;
                o_entry.enable = w_dec.enable & w_dec.auto_reload;
            end
        end else if (i_ctl.copy_next) begin
            o_entry = i_next;
        end else if (i_ctl.write_new) begin
            o_entry = i_new;
        end else if (i_ctl.set_ready) begin
            o_entry.count  = 32'd0;
            o_entry.enable = 1'b1;
        end else if (i_ctl.set_reset) begin
            o_entry.count  = w_dec.reload;
            o_entry.enable = 1'b1;
        end else if (i_ctl.set_pause) begin
            o_entry.enable = 1'b0;
        end else if (i_ctl.set_resume) begin
            o_entry.enable = 1'b1;
        end else begin
            o_entry = w_dec;
        end
    end

endmodule

@@ sv/grouped_soft_timer_bank.sv @@
// top level of the grouped soft timer bank: timer chain, sequencer, result register
//
//  channel   | signals                                          | handshake
//  ----------+--------------------------------------------------+-----------------------
//  command   | i_kind i_group i_timer i_reload_value            | i_start && !o_busy
//            | i_reload_enable i_run_enable                     |
//  config    | i_cfg_index i_cfg_data                           | i_cfg_valid && o_cfg_ready
//  result    | o_status o_fired o_timer_index o_tick_total o_last | o_strobe, one cycle
//
// a command with a bad group or timer index, or a create into a full group, gives its
// single result the cycle after acceptance and keeps busy low.
// any other command rotates the whole chain once, one entry per cycle through the head
// update unit; busy stays high through the rotation and the final state.
// firings come out during the rotation, the last with the final result as busy falls.
// config is taken only while idle with no command offered.
// reset clears the sequencer, group lengths, tick counter and config; the timer entries
// are not cleared. results cannot be stalled.
module grouped_soft_timer_bank #(
    parameter int MAX_GROUPS       = 4,
    parameter int TIMERS_PER_GROUP = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_kind,
    input  logic [1:0]  i_group,
    input  logic [3:0]  i_timer,
    input  logic [31:0] i_reload_value,
    input  logic        i_reload_enable,
    input  logic        i_run_enable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [3:0]  o_timer_index,
    output logic [31:0] o_tick_total,
    output logic        o_last
);

    localparam int SLOTS = MAX_GROUPS * TIMERS_PER_GROUP;
    localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int PW    = (TIMERS_PER_GROUP > 1) ? $clog2(TIMERS_PER_GROUP) : 1;
    localparam int LW    = $clog2(TIMERS_PER_GROUP + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [2:0]          r_groups_in_use;
    logic                r_tick_runs;
    logic [31:0]         r_tick;
    logic [LW-1:0]       r_glen [MAX_GROUPS];
    gstb_pkg::t_kind     r_kind;
    logic [GIW-1:0]      r_g;
    logic [3:0]          r_t;
    logic [LW-1:0]       r_tlen;
    gstb_pkg::t_entry    r_new;
    logic [GIW-1:0]      r_grp;
    logic [PW-1:0]       r_pos;
    logic                r_pend_v;
    logic [3:0]          r_pend_idx;

    logic [3:0]          w_ng;
    logic [GIW-1:0]      w_gidx;
    logic                w_group_ok;
    logic [LW-1:0]       w_glen_sel;
    logic                w_timer_ok;
    logic                w_full;
    logic                w_accept;
    logic                w_is_err;
    logic                w_shift;
    logic                w_last_slot;
    logic                w_cur_live;
    logic                w_in_len;
    logic                w_tgt;
    logic                w_at_t;
    gstb_pkg::t_slot_ctl w_ctl;
    gstb_pkg::t_entry    w_proc_out;
    gstb_pkg::t_entry    w_next;
    logic                w_fire;
    gstb_pkg::t_entry    w_cell [SLOTS];

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_tick_total = r_tick;

    assign w_ng = ({1'b0, r_groups_in_use} > 4'(MAX_GROUPS)) ? 4'(MAX_GROUPS)
                                                             : {1'b0, r_groups_in_use};
    assign w_gidx     = GIW'(i_group);
    assign w_group_ok = (4'(i_group) < w_ng);
    assign w_glen_sel = w_group_ok ? r_glen[w_gidx] : '0;
    assign w_timer_ok = (8'(i_timer) < 8'(w_glen_sel));
    assign w_full     = (w_glen_sel >= LW'(TIMERS_PER_GROUP));
    assign w_accept   = i_start && !o_busy;

    always_comb begin
        w_is_err = 1'b0;
        if (gstb_pkg::t_kind'(i_kind) != gstb_pkg::KIND_TICK) begin
            if (!w_group_ok) begin
                w_is_err = 1'b1;
            end else if (gstb_pkg::t_kind'(i_kind) == gstb_pkg::KIND_CREATE) begin
                w_is_err = w_full;
            end else if (gstb_pkg::t_kind'(i_kind) != gstb_pkg::KIND_RUN) begin
                w_is_err = !w_timer_ok;
            end
        end
    end

    // per-slot control for the entry at the head
    assign w_shift     = (r_state == S_PASS);
    assign w_last_slot = (r_grp == GIW'(MAX_GROUPS - 1)) && (r_pos == PW'(TIMERS_PER_GROUP - 1));
    assign w_cur_live  = (4'(r_grp) < w_ng);
    assign w_in_len    = (LW'(r_pos) < r_glen[r_grp]);
    assign w_tgt       = (r_grp == r_g);
    assign w_at_t      = w_tgt && (8'(r_pos) == 8'(r_t));

    always_comb begin
        w_ctl = '0;
        unique case (r_kind)
            gstb_pkg::KIND_TICK: begin
                w_ctl.dec   = w_cur_live && w_in_len;
                w_ctl.check = r_tick_runs && (r_grp == '0) && w_cur_live && w_in_len;
            end
            gstb_pkg::KIND_RUN: begin
                w_ctl.check = w_tgt && w_in_len;
            end
            gstb_pkg::KIND_CREATE: begin
                w_ctl.write_new = w_tgt && (LW'(r_pos) == r_tlen);
            end
            gstb_pkg::KIND_REMOVE: begin
                w_ctl.copy_next = w_tgt && (8'(r_pos) >= 8'(r_t))
                                  && ((8'(r_pos) + 8'd1) < 8'(r_tlen));
            end
            gstb_pkg::KIND_READY:  w_ctl.set_ready  = w_at_t;
            gstb_pkg::KIND_RESET:  w_ctl.set_reset  = w_at_t;
            gstb_pkg::KIND_PAUSE:  w_ctl.set_pause  = w_at_t;
            gstb_pkg::KIND_RESUME: w_ctl.set_resume = w_at_t;
            default: w_ctl = '0;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            if (gi == SLOTS - 1) begin : g_tail
                gstb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_proc_out),
                    .o_q     (w_cell[gi])
                );
            end else begin : g_body
                gstb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_cell[gi+1]),
                    .o_q     (w_cell[gi])
                );
            end
        end
        if (SLOTS > 1) begin : g_next
            assign w_next = w_cell[1];
        end else begin : g_self
            assign w_next = w_cell[0];
        end
    endgenerate

    gstb_proc u_proc (
        .i_ctl   (w_ctl),
        .i_head  (w_cell[0]),
        .i_next  (w_next),
        .i_new   (r_new),
        .o_entry (w_proc_out),
        .o_fire  (w_fire)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_groups_in_use <= '0;
            r_tick_runs     <= 1'b0;
            r_tick          <= '0;
            r_pend_v        <= 1'b0;
            o_strobe        <= 1'b0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_glen[i] <= '0;
            end
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    gstb_pkg::CFG_GROUPS_IN_USE: r_groups_in_use <= i_cfg_data[2:0];
                    gstb_pkg::CFG_TICK_RUNS:     r_tick_runs     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind     <= gstb_pkg::t_kind'(i_kind);
                        r_g        <= w_gidx;
                        r_t        <= i_timer;
                        r_tlen     <= w_glen_sel;
                        r_new      <= '{count: i_reload_value, reload: i_reload_value,
                                        auto_reload: i_reload_enable, enable: i_run_enable};
                        r_grp      <= '0;
                        r_pos      <= '0;
                        r_pend_v   <= 1'b0;
                        r_pend_idx <= '0;
                        if (gstb_pkg::t_kind'(i_kind) == gstb_pkg::KIND_TICK) begin
                            r_tick <= r_tick + 32'd1;
                        end
                        if (w_is_err) begin
                            o_strobe      <= 1'b1;
                            o_status      <= (w_group_ok && gstb_pkg::t_kind'(i_kind)
                                              == gstb_pkg::KIND_CREATE) ? gstb_pkg::ST_FULL
                                                                        : gstb_pkg::ST_BAD;
                            o_fired       <= 1'b0;
                            o_timer_index <= '0;
                            o_last        <= 1'b1;
                        end else begin
                            r_state <= S_PASS;
                            if (gstb_pkg::t_kind'(i_kind) == gstb_pkg::KIND_CREATE) begin
                                r_glen[w_gidx] <= w_glen_sel + LW'(1);
                                r_pend_idx     <= 4'(w_glen_sel);
                            end else if (gstb_pkg::t_kind'(i_kind) == gstb_pkg::KIND_REMOVE) begin
                                r_glen[w_gidx] <= w_glen_sel - LW'(1);
                            end
                        end
                    end
                end
                S_PASS: begin
                    if (w_fire) begin
                        if (r_pend_v) begin
                            o_strobe      <= 1'b1;
                            o_status      <= gstb_pkg::ST_OK;
                            o_fired       <= 1'b1;
                            o_timer_index <= r_pend_idx;
                            o_last        <= 1'b0;
                        end
                        r_pend_v   <= 1'b1;
                        r_pend_idx <= 4'(r_pos);
                    end
                    if (r_pos == PW'(TIMERS_PER_GROUP - 1)) begin
                        r_pos <= '0;
                        r_grp <= r_grp + GIW'(1);
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                    if (w_last_slot) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_strobe      <= 1'b1;
                    o_status      <= gstb_pkg::ST_OK;
                    o_fired       <= r_pend_v;
                    o_timer_index <= r_pend_idx;
                    o_last        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_nonfinal_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> (r_state == S_PASS) || (r_state == S_FIN))
        else $error("non-final result outside a rotation");

    a_accept_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_strobe && o_last) || (r_state == S_PASS))
        else $error("accepted command neither answered nor started");

    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) && w_last_slot |=> (r_state == S_FIN))
        else $error("rotation did not finish after the last slot");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_strobe && o_last && (r_state == S_IDLE))
        else $error("final result missing after rotation");

endmodule

@@ sim/tb_grouped_soft_timer_bank.sv @@
// self-checking testbench of the grouped soft timer bank: directed table, then random phases
module tb_grouped_soft_timer_bank;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_GROUPS    = 4;
    localparam int PER_GROUP   = 16;
    localparam int SLOTS       = N_GROUPS * PER_GROUP;
    localparam int ROTATION    = SLOTS + 1;
    localparam int STALL_LIMIT = 1000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 15;

    typedef struct {
        gstb_pkg::t_kind kind;
        logic [1:0]      group;
        logic [3:0]      timer;
        logic [31:0]     reload;
        logic            auto_rl;
        logic            run_en;
    } t_cmd;

    typedef struct {
        logic [1:0]  status;
        logic        fired;
        logic [3:0]  idx;
        logic [31:0] ticks;
        logic        last;
    } t_outcome;

    typedef struct {
        logic       is_cfg;
        logic       cfg_idx;
        logic [7:0] cfg_data;
        t_cmd       cmd;
        int         reps;
        logic       typed;
        logic [1:0] st;
        logic [3:0] ix;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [2:0]  i_kind;
    logic [1:0]  i_group;
    logic [3:0]  i_timer;
    logic [31:0] i_reload_value;
    logic        i_reload_enable;
    logic        i_run_enable;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [3:0]  o_timer_index;
    logic [31:0] o_tick_total;
    logic        o_last;

    grouped_soft_timer_bank #(
        .MAX_GROUPS       (N_GROUPS),
        .TIMERS_PER_GROUP (PER_GROUP)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_kind          (i_kind),
        .i_group         (i_group),
        .i_timer         (i_timer),
        .i_reload_value  (i_reload_value),
        .i_reload_enable (i_reload_enable),
        .i_run_enable    (i_run_enable),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_fired         (o_fired),
        .o_timer_index   (o_timer_index),
        .o_tick_total    (o_tick_total),
        .o_last          (o_last)
    );

    // shadow copy of the timer bank
    logic [31:0] shadow_count  [SLOTS];
    logic [31:0] shadow_reload [SLOTS];
    logic        shadow_auto   [SLOTS];
    logic        shadow_en     [SLOTS];
    int          shadow_len    [N_GROUPS];
    logic [31:0] shadow_ticks;
    logic [2:0]  shadow_groups;
    logic        shadow_tick_runs;

    t_outcome    step_out[$];
    t_outcome    due_results[$];
    t_row        directed[$];

    int unsigned n_fail;
    int unsigned n_cmds;
    int unsigned n_results;
    int unsigned n_fired;
    int unsigned n_cfg;
    int unsigned quiet_left;
    int unsigned idle_cycles;

    function automatic t_row op(gstb_pkg::t_kind k, logic [1:0] g, logic [3:0] t,
                                logic [31:0] rv, logic are, logic ren, logic typed,
                                logic [1:0] st, logic [3:0] ix, int reps = 1);
        t_row r;
        r.is_cfg       = 1'b0;
        r.cfg_idx      = 1'b0;
        r.cfg_data     = 8'd0;
        r.cmd.kind     = k;
        r.cmd.group    = g;
        r.cmd.timer    = t;
        r.cmd.reload   = rv;
        r.cmd.auto_rl  = are;
        r.cmd.run_en   = ren;
        r.reps         = reps;
        r.typed        = typed;
        r.st           = st;
        r.ix           = ix;
        return r;
    endfunction

    function automatic t_row cfg_row(logic idx, logic [7:0] d);
        t_row r;
        r          = op(gstb_pkg::KIND_TICK, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                        gstb_pkg::ST_OK, 4'd0, 0);
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = d;
        return r;
    endfunction

    function automatic void note(logic [1:0] st, logic f, logic [3:0] ix);
        t_outcome o;
        o.status = st;
        o.fired  = f;
        o.idx    = ix;
        o.ticks  = shadow_ticks;
        o.last   = 1'b0;
        step_out.push_back(o);
    endfunction

    function automatic int live_groups();
        return (shadow_groups > 3'(N_GROUPS)) ? N_GROUPS : int'(shadow_groups);
    endfunction

    function automatic void check_expired(int g);
        int s;
        for (int j = 0; j < shadow_len[g]; j++) begin
            s = g * PER_GROUP + j;
            if (shadow_count[s] == 32'd0) begin
                note(gstb_pkg::ST_OK, 1'b1, 4'(j));
                shadow_count[s] = shadow_reload[s];
                if (!shadow_auto[s]) shadow_en[s] = 1'b0;
            end
        end
    endfunction

    function automatic void timer_bank_step(t_cmd c);
        int ng;
        int g;
        int t;
        int base;
        int s;
        ng   = live_groups();
        g    = int'(c.group);
        t    = int'(c.timer);
        base = g * PER_GROUP;
        s    = base + t;
        step_out.delete();
        if (c.kind == gstb_pkg::KIND_TICK) begin
            shadow_ticks = shadow_ticks + 32'd1;
            for (int i = 0; i < ng; i++) begin
                for (int j = 0; j < shadow_len[i]; j++) begin
                    if (shadow_en[i*PER_GROUP+j] && shadow_count[i*PER_GROUP+j] != 32'd0)
                        shadow_count[i*PER_GROUP+j] = shadow_count[i*PER_GROUP+j] - 32'd1;
                end
            end
            if (shadow_tick_runs && ng > 0) check_expired(0);
            if (step_out.size() == 0) note(gstb_pkg::ST_OK, 1'b0, 4'd0);
        end else if (g >= ng) begin
            note(gstb_pkg::ST_BAD, 1'b0, 4'd0);
        end else if (c.kind == gstb_pkg::KIND_RUN) begin
            check_expired(g);
            if (step_out.size() == 0) note(gstb_pkg::ST_OK, 1'b0, 4'd0);
        end else if (c.kind == gstb_pkg::KIND_CREATE) begin
            if (shadow_len[g] >= PER_GROUP) begin
                note(gstb_pkg::ST_FULL, 1'b0, 4'd0);
            end else begin
                s = base + shadow_len[g];
                shadow_count[s]  = c.reload;
                shadow_reload[s] = c.reload;
                shadow_auto[s]   = c.auto_rl;
                shadow_en[s]     = c.run_en;
                note(gstb_pkg::ST_OK, 1'b0, 4'(shadow_len[g]));
                shadow_len[g]++;
            end
        end else if (t >= shadow_len[g]) begin
            note(gstb_pkg::ST_BAD, 1'b0, 4'd0);
        end else begin
            case (c.kind)
                gstb_pkg::KIND_REMOVE: begin
                    for (int j = t; j + 1 < shadow_len[g]; j++) begin
                        shadow_count[base+j]  = shadow_count[base+j+1];
                        shadow_reload[base+j] = shadow_reload[base+j+1];
                        shadow_auto[base+j]   = shadow_auto[base+j+1];
                        shadow_en[base+j]     = shadow_en[base+j+1];
                    end
                    shadow_len[g]--;
                end
                gstb_pkg::KIND_READY: begin
                    shadow_count[s] = 32'd0;
                    shadow_en[s]    = 1'b1;
                end
                gstb_pkg::KIND_RESET: begin
                    shadow_count[s] = shadow_reload[s];
                    shadow_en[s]    = 1'b1;
                end
                gstb_pkg::KIND_PAUSE: shadow_en[s] = 1'b0;
                default:              shadow_en[s] = 1'b1;
            endcase
            note(gstb_pkg::ST_OK, 1'b0, 4'd0);
        end
        step_out[step_out.size()-1].last = 1'b1;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   ng;
        int   pick;
        int   len;
        ng        = live_groups();
        c.kind    = gstb_pkg::KIND_TICK;
        c.group   = 2'($urandom_range(0, 3));
        c.timer   = 4'($urandom_range(0, 15));
        c.reload  = $urandom;
        c.auto_rl = 1'($urandom_range(0, 1));
        c.run_en  = 1'($urandom_range(0, 1));
        // noise: any field combination
        if ($urandom_range(0, 99) < 8) begin
            c.kind = gstb_pkg::t_kind'($urandom_range(0, 7));
            return c;
        end
        pick = int'($urandom_range(0, 99));
        if (pick < 30)      c.kind = gstb_pkg::KIND_TICK;
        else if (pick < 50) c.kind = gstb_pkg::KIND_RUN;
        else if (pick < 66) c.kind = gstb_pkg::KIND_CREATE;
        else if (pick < 73) c.kind = gstb_pkg::KIND_REMOVE;
        else if (pick < 80) c.kind = gstb_pkg::KIND_READY;
        else if (pick < 87) c.kind = gstb_pkg::KIND_RESET;
        else if (pick < 94) c.kind = gstb_pkg::KIND_PAUSE;
        else                c.kind = gstb_pkg::KIND_RESUME;
        if (ng > 0) c.group = 2'($urandom_range(0, ng - 1));
        len = shadow_len[c.group];
        if (len > 0) c.timer = 4'($urandom_range(0, len - 1));
        if ($urandom_range(0, 3) != 0) c.reload = 32'($urandom_range(0, 5));
        return c;
    endfunction

    function int unsigned draw_gap();
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(5, 15);
        return $urandom_range(0, 12);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic issue(t_cmd c, int unsigned gap, logic typed, logic [1:0] st,
                         logic [3:0] ix);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_kind          <= c.kind;
        i_group         <= c.group;
        i_timer         <= c.timer;
        i_reload_value  <= c.reload;
        i_reload_enable <= c.auto_rl;
        i_run_enable    <= c.run_en;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        timer_bank_step(c);
        if (typed) begin
            step_out[0].status = st;
            step_out[0].fired  = 1'b0;
            step_out[0].idx    = ix;
        end
        foreach (step_out[k]) due_results.push_back(step_out[k]);
        n_cmds++;
    endtask

    task automatic write_reg(logic idx, logic [7:0] d);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0 || o_busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == gstb_pkg::CFG_GROUPS_IN_USE) shadow_groups = d[2:0];
        else                                    shadow_tick_runs = d[0];
        n_cfg++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result checking
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (o_fired) n_fired++;
            if (due_results.size() == 0) begin
                $error("unexpected result transaction: status %0d timer_index %0d",
                       o_status, o_timer_index);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("fired", 32'(want.fired), 32'(o_fired));
                check_field("timer_index", 32'(want.idx), 32'(o_timer_index));
                check_field("tick_total", want.ticks, o_tick_total);
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, due_results.size());
        $display("** grouped_soft_timer_bank: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_kind          <= gstb_pkg::KIND_TICK;
        i_group         <= 2'd0;
        i_timer         <= 4'd0;
        i_reload_value  <= 32'd0;
        i_reload_enable <= 1'b0;
        i_run_enable    <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= gstb_pkg::CFG_GROUPS_IN_USE;
        i_cfg_data      <= 8'd0;
        idle_cycles     = 0;
        n_fail          = 0;
        n_cmds          = 0;
        n_results       = 0;
        n_fired         = 0;
        n_cfg           = 0;
        quiet_left      = 0;
        for (int s = 0; s < SLOTS; s++) begin
            shadow_count[s]  = 32'd0;
            shadow_reload[s] = 32'd0;
            shadow_auto[s]   = 1'b0;
            shadow_en[s]     = 1'b0;
        end
        for (int g = 0; g < N_GROUPS; g++) shadow_len[g] = 0;
        shadow_ticks     = 32'd0;
        shadow_groups    = 3'd0;
        shadow_tick_runs = 1'b0;

        // no groups in use after reset
        directed.push_back(op(gstb_pkg::KIND_TICK, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RUN, 2'd3, 4'd15, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_BAD, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1,
                              1'b1, gstb_pkg::ST_BAD, 4'd0));
        // groups_in_use above the maximum saturates
        directed.push_back(cfg_row(gstb_pkg::CFG_GROUPS_IN_USE, 8'hFF));
        directed.push_back(cfg_row(gstb_pkg::CFG_TICK_RUNS, 8'h00));
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd0, 4'd0, 32'd0, 1'b1, 1'b1, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                              1'b1, gstb_pkg::ST_OK, 4'd1));
        // disabled timer sitting at zero
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd2));
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd3, 4'd0, 32'd1, 1'b1, 1'b1, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RUN, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_TICK, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RUN, 2'd3, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_REMOVE, 2'd0, 4'd15, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_BAD, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_PAUSE, 2'd0, 4'd1, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_READY, 2'd0, 4'd2, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RESUME, 2'd0, 4'd1, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RESET, 2'd0, 4'd1, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_REMOVE, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(cfg_row(gstb_pkg::CFG_TICK_RUNS, 8'h01));
        directed.push_back(op(gstb_pkg::KIND_TICK, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RUN, 2'd2, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        // tick with group zero out of use
        directed.push_back(cfg_row(gstb_pkg::CFG_GROUPS_IN_USE, 8'h00));
        directed.push_back(op(gstb_pkg::KIND_TICK, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(cfg_row(gstb_pkg::CFG_GROUPS_IN_USE, 8'h02));
        directed.push_back(op(gstb_pkg::KIND_RUN, 2'd2, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_BAD, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_PAUSE, 2'd1, 4'd0, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_BAD, 4'd0));
        // fill a group, then one too many
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd1, 4'd0, 32'd3, 1'b1, 1'b1, 1'b0,
                              gstb_pkg::ST_OK, 4'd0, PER_GROUP));
        directed.push_back(op(gstb_pkg::KIND_CREATE, 2'd1, 4'd0, 32'd5, 1'b0, 1'b1, 1'b1,
                              gstb_pkg::ST_FULL, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_REMOVE, 2'd1, 4'd15, 32'd0, 1'b0, 1'b0, 1'b1,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_TICK, 2'd0, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                              gstb_pkg::ST_OK, 4'd0));
        directed.push_back(op(gstb_pkg::KIND_RUN, 2'd1, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                              gstb_pkg::ST_OK, 4'd0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            if (directed[r].is_cfg)
                write_reg(directed[r].cfg_idx, directed[r].cfg_data);
            else
                repeat (directed[r].reps)
                    issue(directed[r].cmd, draw_gap(), directed[r].typed, directed[r].st,
                          directed[r].ix);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(gstb_pkg::CFG_GROUPS_IN_USE, 8'h04);
                    write_reg(gstb_pkg::CFG_TICK_RUNS, 8'h01);
                end
                1: begin
                    write_reg(gstb_pkg::CFG_GROUPS_IN_USE, 8'hFF);
                    write_reg(gstb_pkg::CFG_TICK_RUNS, 8'hFE);
                end
                2: begin
                    write_reg(gstb_pkg::CFG_GROUPS_IN_USE, 8'h01);
                    write_reg(gstb_pkg::CFG_TICK_RUNS, 8'hFF);
                end
                default: begin
                    write_reg(gstb_pkg::CFG_GROUPS_IN_USE, 8'($urandom_range(0, 255)));
                    write_reg(gstb_pkg::CFG_TICK_RUNS, 8'($urandom_range(0, 255)));
                end
            endcase
            repeat (PHASE_ITEMS) issue(random_cmd(), draw_gap(), 1'b0, gstb_pkg::ST_OK, 4'd0);
        end

        i_start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (ROTATION + 8) @(posedge i_clk);

        $display("covered %0d commands over %0d register writes and %0d configuration phases",
                 n_cmds, n_cfg, N_PHASES);
        $display("checked %0d result transactions, %0d of them timer firings",
                 n_results, n_fired);
        if (n_fail == 0)
            $display("** grouped_soft_timer_bank: PASSED **");
        else
            $display("** grouped_soft_timer_bank: FAILED **");
        $finish;
    end

endmodule
